// ===== src/pohv_pkg.sv =====
// shared types and constants for the plane offset histogram vote block
`default_nettype none
package pohv_pkg;

  // input action codes
  localparam logic [1:0] ACT_VOTE   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_SHIFT  = 2'd2;

  // result kind codes
  localparam logic KIND_VOTE  = 1'b0;
  localparam logic KIND_SHIFT = 1'b1;

  // configuration register indexes
  localparam logic [7:0] REG_NORMAL_X = 8'd0;
  localparam logic [7:0] REG_NORMAL_Y = 8'd1;
  localparam logic [7:0] REG_NORMAL_Z = 8'd2;
  localparam logic [7:0] REG_OFFSET   = 8'd3;

  // axis select for the shared multiplier
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // distance accumulator at q.32: three 50-bit products plus offset << 16
  localparam int ACC_W  = 52;
  // magnitude bits of a positive distance
  localparam int MAG_W  = 50;
  // bin index before range check: (mag * 200) >> 32
  localparam int BINX_W = MAG_W + 8 - 32;
  // peak distance, unsigned with 16 fraction bits (q5.16), for up to 4096 bins
  localparam int DIST_W = 21;

  // one bin step is 0.005 m = 32768 / 100 in q16.16
  localparam logic [DIST_W-1:0] STEP_Q   = 21'd327;
  localparam logic [7:0]        STEP_R   = 8'd68;
  localparam logic [7:0]        DIV_BASE = 8'd100;
  localparam logic [7:0]        ROUND_R0 = 8'd50;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VMUL,
    ST_VBIN,
    ST_VRD,
    ST_VWR,
    ST_SCAN,
    ST_SCAN_END,
    ST_DMUL,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       clear_wr;
    logic       scan_rd;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       mul_dist;
    logic       acc_init;
    logic       acc_add;
    logic       bin_en;
    logic       vote_rd;
    logic       vote_wr;
    logic       disp_en;
    logic [1:0] disp_sel;
    logic       off_commit;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       cnt_last;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/pohv_ctrl.sv =====
// controller state machine sequencing votes, the finish scan and result loads
`default_nettype none
module pohv_ctrl
  import pohv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  // state and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = 2'd0;
    case (state_r)
      ST_CLEAR: begin
        if (status.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (status.action)
            ACT_VOTE:   state_nxt = ST_VMUL;
            ACT_FINISH: state_nxt = ST_SCAN;
            ACT_SHIFT:  state_nxt = ST_LOAD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_VMUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) state_nxt = ST_VBIN;
      end
      ST_VBIN:     state_nxt = ST_VRD;
      ST_VRD:      state_nxt = ST_VWR;
      ST_VWR:      state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (status.cnt_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_DMUL;
      ST_DMUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_VMUL: begin
        cmd.mul_en   = (step_r != 2'd3);
        cmd.mul_sel  = step_r;
        cmd.acc_init = (step_r == 2'd0);
        cmd.acc_add  = (step_r != 2'd0);
      end
      ST_VBIN: cmd.bin_en  = 1'b1;
      ST_VRD:  cmd.vote_rd = 1'b1;
      ST_VWR:  cmd.vote_wr = 1'b1;
      ST_SCAN: cmd.scan_rd = 1'b1;
      ST_SCAN_END: cmd = '0;
      ST_DMUL: begin
        cmd.mul_en     = (step_r != 2'd3);
        cmd.mul_sel    = step_r;
        cmd.mul_dist   = 1'b1;
        cmd.off_commit = (step_r == 2'd0);
        cmd.disp_en    = (step_r != 2'd0);
        cmd.disp_sel   = step_r - 2'd1;
      end
      ST_LOAD: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

  // a finish word starts the bin scan
  a_finish_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_tvalid && status.action == ACT_FINISH) |=> state_r == ST_SCAN)
    else $error("finish word did not start the scan");

  // the scan ends after the last bin address
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && status.cnt_last) |=> state_r == ST_SCAN_END)
    else $error("scan ran past the last bin");

  // a vote write always follows its bin read
  a_vote_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vote_wr |-> $past(cmd.vote_rd))
    else $error("vote write without a preceding read");

endmodule
`default_nettype wire

// ===== src/pohv_datapath.sv =====
// datapath: distance multiplier, histogram memory, peak scan and result register
`default_nettype none
module pohv_datapath
  import pohv_pkg::*;
#(
  parameter int NUM_BINS   = 200,
  parameter int COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  output status_t            status,
  input  wire logic [95:0]   in_tdata,
  input  wire logic [1:0]    in_tuser,
  input  wire logic          cfg_valid,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [135:0]       out_tdata,
  output logic               out_tuser
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    else if (v[33]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  // configuration and stored vote state
  logic signed [17:0] nx_r, ny_r, nz_r;
  logic signed [31:0] off_r, voted_r;
  logic signed [31:0] sx_r, sy_r, sz_r;

  // captured input word
  logic [1:0]         act_r;
  logic signed [31:0] cx_r, cy_r, cz_r;

  // multiplier and accumulator
  logic signed [17:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [49:0]      mul_p;
  logic signed [49:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // bin selection
  logic [MAG_W+7:0]  scaled;
  logic [BINX_W-1:0] bin_wide;
  logic              acc_pos;
  logic [BIN_W-1:0]  bin_r;
  logic              hit_r;

  // histogram memory
  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_r;
  logic [BIN_W-1:0]      cnt_r;
  logic                  wr_en, rd_en;
  logic [BIN_W-1:0]      wr_addr, rd_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // peak scan
  logic                  scan_v_r;
  logic [BIN_W-1:0]      scan_idx_r;
  logic [COUNT_BITS-1:0] best_r;
  logic [BIN_W-1:0]      peak_r;
  logic [DIST_W-1:0]     q_r, dist_r;
  logic [7:0]            r_r, r_sum;
  logic [BIN_W+7:0]      peak_ext;

  // rounding and saturation
  logic signed [49:0] rnd_sum;
  logic signed [31:0] rnd_q;
  logic signed [31:0] newd;
  logic signed [31:0] shx, shy, shz;

  // output register
  logic         out_valid_r;
  logic [135:0] out_data_r;
  logic         out_kind_r;

  // status back to the controller
  assign status.action   = in_tuser;
  assign status.cnt_last = (cnt_r == BIN_W'(NUM_BINS - 1));
  assign status.out_free = !out_valid_r || out_tready;

  // configuration writes and finish update of the offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r    <= '0;
      ny_r    <= '0;
      nz_r    <= 18'sd65536;
      off_r   <= '0;
      voted_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_NORMAL_X: nx_r  <= cfg_data[17:0];
          REG_NORMAL_Y: ny_r  <= cfg_data[17:0];
          REG_NORMAL_Z: nz_r  <= cfg_data[17:0];
          REG_OFFSET:   off_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.off_commit) begin
        off_r   <= newd;
        voted_r <= newd;
      end
    end
  end

  // capture of the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_tuser;
      cx_r  <= in_tdata[31:0];
      cy_r  <= in_tdata[63:32];
      cz_r  <= in_tdata[95:64];
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      AXIS_X:  begin mul_a = nx_r; mul_b = cx_r; end
      AXIS_Y:  begin mul_a = ny_r; mul_b = cy_r; end
      AXIS_Z:  begin mul_a = nz_r; mul_b = cz_r; end
      default: begin mul_a = nz_r; mul_b = cz_r; end
    endcase
    if (cmd.mul_dist) mul_b = $signed({{(32 - DIST_W){1'b0}}, dist_r});
  end

  assign mul_p = mul_a * mul_b;

  // product register and distance accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_p;
    if (cmd.acc_init) acc_r <= {{(ACC_W - 48){off_r[31]}}, off_r, 16'b0};
    else if (cmd.acc_add) acc_r <= acc_r + {{(ACC_W - 50){prod_r[49]}}, prod_r};
  end

  // bin index: floor(distance * 200 / 2^32) by shifts and adds
  assign acc_pos  = !acc_r[ACC_W-1] && (acc_r != '0);
  assign scaled   = ({8'b0, acc_r[MAG_W-1:0]} << 7) + ({8'b0, acc_r[MAG_W-1:0]} << 6)
                  + ({8'b0, acc_r[MAG_W-1:0]} << 3);
  assign bin_wide = scaled[MAG_W+7:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.bin_en) begin
      hit_r <= acc_pos && (bin_wide < BINX_W'(NUM_BINS));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_en) bin_r <= bin_wide[BIN_W-1:0];
  end

  // histogram port select: clear sweep, scan read-and-clear, vote update
  always_comb begin
    rd_en   = cmd.vote_rd || cmd.scan_rd;
    rd_addr = cmd.vote_rd ? bin_r : cnt_r;
    wr_en   = cmd.clear_wr || cmd.scan_rd
           || (cmd.vote_wr && hit_r && (rd_r != {COUNT_BITS{1'b1}}));
    wr_addr = cmd.vote_wr ? bin_r : cnt_r;
    wr_data = cmd.vote_wr ? rd_r + COUNT_BITS'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  // sweep address counter, wraps after the last bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= cmd.scan_rd;
      if (cmd.clear_wr || cmd.scan_rd) begin
        cnt_r <= status.cnt_last ? '0 : cnt_r + BIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) scan_idx_r <= cnt_r;
  end

  // running peak distance round(idx * 32768 / 100) kept as quotient and remainder
  assign r_sum = r_r + STEP_R;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best_r <= '0;
      peak_r <= '0;
      dist_r <= '0;
      q_r    <= '0;
      r_r    <= ROUND_R0;
    end else if (scan_v_r) begin
      if (scan_idx_r == '0 || rd_r > best_r) begin
        best_r <= rd_r;
        peak_r <= scan_idx_r;
        dist_r <= q_r;
      end
      if (r_sum >= DIV_BASE) begin
        r_r <= r_sum - DIV_BASE;
        q_r <= q_r + STEP_Q + DIST_W'(1);
      end else begin
        r_r <= r_sum;
        q_r <= q_r + STEP_Q;
      end
    end
  end

  // displacement: round-half-up(product / 2^16), saturated
  assign rnd_sum = prod_r + 50'sd32768;
  assign rnd_q   = sat32(rnd_sum[49:16]);
  assign newd    = sat32({{2{off_r[31]}}, off_r} - $signed({13'b0, dist_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      sz_r <= '0;
    end else if (cmd.disp_en) begin
      case (cmd.disp_sel)
        AXIS_X:  sx_r <= rnd_q;
        AXIS_Y:  sy_r <= rnd_q;
        AXIS_Z:  sz_r <= rnd_q;
        default: ;
      endcase
    end
  end

  // shifted reference point
  assign shx = sat32({{2{cx_r[31]}}, cx_r} + {{2{sx_r[31]}}, sx_r});
  assign shy = sat32({{2{cy_r[31]}}, cy_r} + {{2{sy_r[31]}}, sy_r});
  assign shz = sat32({{2{cz_r[31]}}, cz_r} + {{2{sz_r[31]}}, sz_r});

  assign peak_ext = {8'b0, peak_r};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (act_r == ACT_SHIFT) begin
        out_kind_r <= KIND_SHIFT;
        out_data_r <= {8'b0, 32'b0, shz, shy, shx};
      end else begin
        out_kind_r <= KIND_VOTE;
        out_data_r <= {peak_ext[7:0], voted_r, sz_r, sy_r, sx_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule
`default_nettype wire

// ===== src/plane_offset_histogram_vote.sv =====
// top level of the plane offset histogram vote block
//
//  channel  direction  handshake              payload
//  in_      input      in_tvalid/in_tready    tdata x,y,z; tuser action
//  out_     output     out_tvalid/out_tready  tdata x,y,z,offset,peak; tuser kind
//  cfg_     input      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a vote word makes three passes through the one 18x32 multiplier, then the bin
// compute and a read-modify-write of the bin memory.
// a finish word runs the read-and-clear scan of the bin memory, one address per
// cycle, then the displacement multiplies; a shift goes straight to the load.
// after reset a clearing pass over every bin zeroes the bins; no input word
// is taken then, configuration writes are. a stalled result holds in the output
// register while vote words keep flowing; a finish or shift waits for it.
`default_nettype none
module plane_offset_histogram_vote
  import pohv_pkg::*;
#(
  parameter int NUM_BINS   = 200,
  parameter int COUNT_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // coord_x, coord_y, coord_z
  input  wire logic [1:0]   in_tuser,   // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // out_x, out_y, out_z, new_offset, peak_bin
  output logic              out_tuser,  // kind
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  pohv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pohv_datapath #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== verif/pohv_checker.sv =====
// checker for the plane offset histogram vote block: models the voting and checks results
`default_nettype none
module pohv_checker
  import pohv_pkg::*;
#(
  parameter int NUM_BINS   = 200,
  parameter int COUNT_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [95:0]  in_tdata,   // coord_x, coord_y, coord_z
  input  wire logic [1:0]   in_tuser,   // action
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [135:0] out_tdata,  // out_x, out_y, out_z, new_offset, peak_bin
  input  wire logic         out_tuser,  // kind
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  output int                fail_count,
  output int                results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // one bin is 0.005 m, so 200 bins per metre
  localparam longint BINS_PER_M = 200;
  localparam longint Q_HI       = 64'sd2147483647;
  localparam longint Q_LO       = -64'sd2147483648;

  typedef struct {
    logic        kind;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] offset;
    logic [7:0]  peak;
  } outcome_t;

  // plane and vote state as the block should hold it
  longint   nrm_x, nrm_y, nrm_z, plane_d;
  longint   disp_x, disp_y, disp_z;
  longint   bin_count [NUM_BINS];
  outcome_t outcomes_due [$];

  function automatic longint clamp32(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  task automatic clear_bins();
    int i;
    for (i = 0; i < NUM_BINS; i++) bin_count[i] = 0;
  endtask

  task automatic reset_model();
    clear_bins();
    nrm_x = 0;
    nrm_y = 0;
    nrm_z = 65536;
    plane_d = 0;
    disp_x = 0;
    disp_y = 0;
    disp_z = 0;
    outcomes_due.delete();
  endtask

  // normals are 18-bit signed, the offset is a full 32-bit word
  task automatic apply_reg(input logic [7:0] idx, input logic [31:0] val);
    case (idx)
      REG_NORMAL_X: nrm_x = longint'($signed(val[17:0]));
      REG_NORMAL_Y: nrm_y = longint'($signed(val[17:0]));
      REG_NORMAL_Z: nrm_z = longint'($signed(val[17:0]));
      REG_OFFSET:   plane_d = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic predict_outcome(input logic [1:0] act, input logic [95:0] data);
    longint   px, py, pz, dist_q32, bin, peak_dist, newd;
    longint   count_max;
    int       i, peak;
    outcome_t o;
    px = longint'($signed(data[31:0]));
    py = longint'($signed(data[63:32]));
    pz = longint'($signed(data[95:64]));
    count_max = (64'sd1 <<< COUNT_BITS) - 1;
    case (act)
      ACT_VOTE: begin
        // signed distance at q.32, only positive ones vote
        dist_q32 = nrm_x * px + nrm_y * py + nrm_z * pz + plane_d * 65536;
        if (dist_q32 > 0) begin
          bin = (dist_q32 * BINS_PER_M) >>> 32;
          if (bin < NUM_BINS && bin_count[bin] < count_max) bin_count[bin]++;
        end
      end
      ACT_FINISH: begin
        // first bin with the most votes wins
        peak = 0;
        for (i = 1; i < NUM_BINS; i++) begin
          if (bin_count[i] > bin_count[peak]) peak = i;
        end
        peak_dist = (longint'(peak) * 32768 + 50) / 100;
        newd = clamp32(plane_d - peak_dist);
        disp_x = clamp32((peak_dist * nrm_x + 32768) >>> 16);
        disp_y = clamp32((peak_dist * nrm_y + 32768) >>> 16);
        disp_z = clamp32((peak_dist * nrm_z + 32768) >>> 16);
        plane_d = newd;
        clear_bins();
        o.kind = KIND_VOTE;
        o.dx = disp_x[31:0];
        o.dy = disp_y[31:0];
        o.dz = disp_z[31:0];
        o.offset = newd[31:0];
        o.peak = peak[7:0];
        outcomes_due = {outcomes_due, o};
      end
      ACT_SHIFT: begin
        px = clamp32(px + disp_x);
        py = clamp32(py + disp_y);
        pz = clamp32(pz + disp_z);
        o.kind = KIND_SHIFT;
        o.dx = px[31:0];
        o.dy = py[31:0];
        o.dz = pz[31:0];
        o.offset = '0;
        o.peak = '0;
        outcomes_due = {outcomes_due, o};
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      reset_model();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) predict_outcome(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h kind %b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("out_x", want.dx, out_tdata[31:0]);
          check_field("out_y", want.dy, out_tdata[63:32]);
          check_field("out_z", want.dz, out_tdata[95:64]);
          check_field("new_offset", want.offset, out_tdata[127:96]);
          check_field("peak_bin", 32'(want.peak), 32'(out_tdata[135:128]));
        end
      end
    end
    results_owed <= outcomes_due.size();
  end

endmodule
`default_nettype wire

// ===== verif/plane_offset_histogram_vote_test.sv =====
// testbench top for the plane offset histogram vote block: stimulus, flow control and verdict
`default_nettype none
module plane_offset_histogram_vote_test
  import pohv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BINS    = 200;
  // narrow counts so that full bins come within reach
  localparam int COUNT_BITS  = 4;
  localparam int DRAIN_PAD   = NUM_BINS + 50;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int WORD_TARGET = 750;
  localparam int QUIET_FROM  = 690;
  localparam int HOLD_AT     = 300;

  // action code the block does not decode
  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  // register index the block does not decode
  localparam logic [7:0]  REG_SPARE  = 8'd9;
  localparam logic [31:0] Q_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN      = 32'h8000_0000;

  logic          clk        = 1'b0;
  logic          rst_n      = 1'b0;
  logic          in_tvalid  = 1'b0;
  logic [95:0]   in_tdata   = '0;
  logic [1:0]    in_tuser   = ACT_VOTE;
  logic          out_tready = 1'b0;
  logic          cfg_valid  = 1'b0;
  logic [7:0]    cfg_index  = REG_NORMAL_X;
  logic [31:0]   cfg_data   = '0;
  logic          in_tready;
  logic          out_tvalid;
  logic [135:0]  out_tdata;
  logic          out_tuser;
  logic          cfg_ready;
  int            fail_count;
  int            results_owed;

  // flow control between the stimulus and the result sink
  bit            quiet     = 1'b0;
  bit            calm      = 1'b0;
  bit            hold_req  = 1'b0;
  bit            hold_done = 1'b0;
  int            words_sent = 0;
  int            cycles     = 0;
  // plane as last written, used to aim clusters
  longint        aim_nx = 0, aim_ny = 0, aim_nz = 65536;

  plane_offset_histogram_vote #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pohv_checker #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result sink: random ready bursts, one long hold on request
  initial begin : result_sink
    int span;
    bit hold_taken;
    span = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        span = LONG_HOLD;
      end else if (span == 0) begin
        if (quiet || $urandom_range(0, 3) != 0) begin
          out_tready <= 1'b1;
          span = $urandom_range(1, 40);
        end else begin
          out_tready <= 1'b0;
          span = $urandom_range(1, 10);
        end
      end
      span--;
    end
  end

  // offer one input word, idling first now and then
  task automatic send_word(input logic [1:0] act, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
    if (act != ACT_UNUSED) words_sent++;
  endtask

  // stop sending and wait until every result is in and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // write the registers picked by sel: normal x, y, z, offset, spare index
  task automatic program_plane(input longint nx, input longint ny, input longint nz,
                               input longint d, input logic [4:0] sel);
    logic [7:0]  idx [5];
    logic [31:0] val [5];
    int          r;
    bit          any;
    idx = '{REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z, REG_OFFSET, REG_SPARE};
    val[0] = $urandom();
    val[0][17:0] = nx[17:0];
    val[1] = $urandom();
    val[1][17:0] = ny[17:0];
    val[2] = $urandom();
    val[2][17:0] = nz[17:0];
    val[3] = d[31:0];
    val[4] = $urandom();
    any = 1'b0;
    for (r = 0; r < 5; r++) begin
      if (sel[r]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx[r];
        cfg_data <= val[r];
        do @(posedge clk); while (!cfg_ready);
        any = 1'b1;
      end
    end
    if (any) cfg_valid <= 1'b0;
    if (sel[0]) aim_nx = nx;
    if (sel[1]) aim_ny = ny;
    if (sel[2]) aim_nz = nz;
  endtask

  function automatic longint pick_normal();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65536;
      2: return -65536;
      3: return 131071;
      4: return -131072;
      default: return longint'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'($urandom_range(0, 262144)) - 32'd131072;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] near(input longint c, input longint spread);
    return 32'(c + longint'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // a burst of mostly votes around one point, usually a finish, then a few shifted points
  task automatic run_cluster();
    longint cx, cy, cz, nx, ny, nz, goal, dot, spread;
    int     n_votes, n_shifts, k;
    logic [4:0] sel;
    calm = ($urandom_range(0, 3) == 0);
    cx = longint'($urandom_range(0, 262144)) - 131072;
    cy = longint'($urandom_range(0, 262144)) - 131072;
    cz = longint'($urandom_range(0, 262144)) - 131072;
    if ($urandom_range(0, 3) != 0) begin
      settle();
      sel[2:0] = 3'($urandom_range(0, 7));
      sel[3] = 1'b1;
      sel[4] = ($urandom_range(0, 7) == 0);
      nx = sel[0] ? pick_normal() : aim_nx;
      ny = sel[1] ? pick_normal() : aim_ny;
      nz = sel[2] ? pick_normal() : aim_nz;
      // place the plane so the cluster sits at the chosen distance
      case ($urandom_range(0, 9))
        0: goal = -longint'($urandom_range(0, 10000));
        1: goal = 65536 + longint'($urandom_range(0, 15000));
        default: goal = longint'($urandom_range(0, 65535));
      endcase
      dot = nx * cx + ny * cy + nz * cz;
      program_plane(nx, ny, nz, goal - (dot >>> 16), sel);
    end
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 100;
      2: spread = 700;
      default: spread = 3000;
    endcase
    n_votes = $urandom_range(1, 30);
    for (k = 0; k < n_votes; k++) begin
      case ($urandom_range(0, 15))
        0: send_word(ACT_VOTE, any_coord(), any_coord(), any_coord());
        1: send_word(ACT_SHIFT, any_coord(), any_coord(), any_coord());
        2: send_word(ACT_UNUSED, any_coord(), any_coord(), any_coord());
        default: send_word(ACT_VOTE, near(cx, spread), near(cy, spread), near(cz, spread));
      endcase
    end
    if ($urandom_range(0, 7) != 0) send_word(ACT_FINISH, $urandom(), $urandom(), $urandom());
    n_shifts = $urandom_range(0, 3);
    for (k = 0; k < n_shifts; k++) begin
      send_word(ACT_SHIFT, any_coord(), any_coord(), any_coord());
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // finish on an empty histogram, then a shift by zero
    send_word(ACT_FINISH, Q_MAX, Q_MIN, 32'd0);
    send_word(ACT_SHIFT, Q_MAX, Q_MIN, 32'd0);
    // default plane z = 0: the distance is z itself
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'd0);
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'hffff_ffff);
    send_word(ACT_VOTE, Q_MIN, Q_MAX, Q_MAX);
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'd65536);
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'd1);
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'd328);
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'd65535);
    send_word(ACT_VOTE, 32'd0, 32'd0, 32'd65535);
    send_word(ACT_UNUSED, 32'd0, 32'd0, 32'd65535);
    // peak in the last bin
    send_word(ACT_FINISH, 32'd0, 32'd0, 32'd0);
    send_word(ACT_SHIFT, Q_MAX, Q_MIN, Q_MAX);
    send_word(ACT_SHIFT, 32'd12345, 32'hdead_beef, Q_MIN);
    settle();

    // steepest normals with the lowest offset: the new offset saturates
    program_plane(131071, -131072, 0, -64'sd2147483648, 5'b11111);
    send_word(ACT_VOTE, 32'd1073750016, -32'sd16384, 32'd0);
    send_word(ACT_VOTE, 32'd1073750016, -32'sd16384, 32'd0);
    send_word(ACT_FINISH, 32'd0, 32'd0, 32'd0);
    send_word(ACT_SHIFT, Q_MAX, Q_MIN, 32'd0);

    // random clusters, with one long result stall along the way
    while (words_sent < WORD_TARGET) begin
      if (!hold_done && words_sent >= HOLD_AT) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
        for (k = 0; k < 8; k++) send_word(ACT_SHIFT, any_coord(), any_coord(), any_coord());
      end
      quiet = (words_sent >= QUIET_FROM);
      run_cluster();
    end
    settle();

    if (fail_count == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/pohv_pkg.sv
src/pohv_ctrl.sv
src/pohv_datapath.sv
src/plane_offset_histogram_vote.sv
verif/pohv_checker.sv
verif/plane_offset_histogram_vote_test.sv
